// File: rtl/core/dgps_pkg.sv
`default_nettype none

package dgps_pkg;

    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DOY_W     = 9;
    localparam int unsigned WEEK_W    = 19;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned ABS_W     = 23;
    localparam int unsigned ELAPSED_W = 22;
    localparam int unsigned CENT_W    = 8;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EARLY   = 2'd2;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(x / 100) == (x * CENT_RECIP) >> CENT_SHIFT for x < 2**14
    localparam logic [12:0] CENT_RECIP = 13'd5243;
    localparam int unsigned CENT_SHIFT = 19;
    localparam int unsigned PROD_W     = YEAR_W + 13;

    // floor(x / 7) == (x * WEEK_RECIP) >> WEEK_SHIFT for x < 2**22
    localparam logic [22:0] WEEK_RECIP = 23'd4793491;
    localparam int unsigned WEEK_SHIFT = 25;
    localparam int unsigned WPROD_W    = ELAPSED_W + 23;

    localparam logic [ABS_W-1:0] DAYS_PER_YEAR = 23'd365;
    // days before 1 january 1980 counted from year 1, plus six
    localparam logic [ABS_W-1:0] EPOCH_ABS     = 23'd722820;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DOY_W-1:0]    day_of_year;
        logic [WEEK_W-1:0]   gps_week;
        logic [WDAY_W-1:0]   gps_day;
    } gps_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [DOY_W-1:0]     day_of_year;
        logic [ELAPSED_W-1:0] elapsed;
    } span_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] d;
        begin
            case (m)
                4'd2:                       d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
                default:                    d = 5'd31;
            endcase
            return d;
        end
    endfunction

    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] o;
        begin
            case (m)
                4'd2:    o = 9'd31;
                4'd3:    o = 9'd59;
                4'd4:    o = 9'd90;
                4'd5:    o = 9'd120;
                4'd6:    o = 9'd151;
                4'd7:    o = 9'd181;
                4'd8:    o = 9'd212;
                4'd9:    o = 9'd243;
                4'd10:   o = 9'd273;
                4'd11:   o = 9'd304;
                4'd12:   o = 9'd334;
                default: o = 9'd0;
            endcase
            return o;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/date_to_gps_week_day_core.sv
`default_nettype none

// Gregorian date to GPS week and day. One date word is taken on every clock
// at which start is high; busy never rises. Each result word appears on
// result with done high once its date has passed register stages a to e,
// in order, one cycle each, and must be captured then. The register stages
// a to e lie around the two reciprocal multiplies (by 1/100 for the
// leap-year count, by 1/7 for the week split). Status says whether the date
// is valid and on or after 6 January 1980; week and day are zero otherwise.
module date_to_gps_week_day_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire dgps_pkg::date_t date,
    output logic                 done,
    output dgps_pkg::gps_t       result
);
    import dgps_pkg::*;

    logic  span_valid;
    span_t span;

    assign busy = 1'b0;

    dgps_span u_span (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .date       (date),
        .span_valid (span_valid),
        .span       (span)
    );

    // stage d: week quotient
    logic                  d_valid_reg;
    logic [STATUS_W-1:0]   d_status_reg;
    logic [DOY_W-1:0]      d_doy_reg;
    logic [WEEK_W-1:0]     d_week_reg, d_week_next;
    logic [WDAY_W-1:0]     d_low_reg;
    logic [WPROD_W-1:0]    d_prod;

    always_comb
    begin
        d_prod      = {23'd0, span.elapsed} * {{ELAPSED_W{1'b0}}, WEEK_RECIP};
        d_week_next = d_prod[WEEK_SHIFT +: WEEK_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= span_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_status_reg <= span.status;
        d_doy_reg    <= span.day_of_year;
        d_week_reg   <= d_week_next;
        d_low_reg    <= span.elapsed[WDAY_W-1:0];
    end

    // stage e: day within week from the low bits
    logic                  e_valid_reg;
    gps_t                  e_result_reg, e_result_next;
    logic [WDAY_W-1:0]     e_q7;

    always_comb
    begin
        e_q7                        = WDAY_W'({d_week_reg[WDAY_W-1:0], 3'd0}
                                              - {3'd0, d_week_reg[WDAY_W-1:0]});
        e_result_next.status        = d_status_reg;
        e_result_next.day_of_year   = d_doy_reg;
        e_result_next.gps_week      = d_week_reg;
        e_result_next.gps_day       = d_low_reg - e_q7;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_result_reg <= e_result_next;
    end

    assign done   = e_valid_reg;
    assign result = e_result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("result word missing five cycles after start");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result word without a date word");

    a_zero_week: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != STATUS_OK) |->
            (result.gps_week == '0) && (result.gps_day == '0))
        else $error("week or day nonzero on error status");

    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.gps_day <= 3'd6) && (result.status != 2'd3))
        else $error("day of week or status out of range");

    a_invalid_doy: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STATUS_INVALID) |-> (result.day_of_year == '0))
        else $error("ordinal day nonzero on invalid date");

endmodule

`default_nettype wire

// File: rtl/core/dgps_span.sv
`default_nettype none

module dgps_span (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire dgps_pkg::date_t date,
    output logic               span_valid,
    output dgps_pkg::span_t    span
);
    import dgps_pkg::*;

    // stage a: range checks and century quotient of year - 1
    logic                  a_valid_reg;
    logic                  a_ok_reg,    a_ok_next;
    logic [YEAR_W-1:0]     a_p_reg,     a_p_next;
    logic [MONTH_W-1:0]    a_month_reg;
    logic [DAY_W-1:0]      a_day_reg;
    logic [CENT_W-1:0]     a_cent_reg,  a_cent_next;
    logic [PROD_W-1:0]     a_prod;

    always_comb
    begin
        a_p_next    = date.year - 14'd1;
        a_prod      = {13'd0, a_p_next} * {{YEAR_W{1'b0}}, CENT_RECIP};
        a_cent_next = a_prod[CENT_SHIFT +: CENT_W];
        a_ok_next   = (date.year != '0) && (date.year <= MAX_YEAR)
                   && (date.month >= MONTH_JAN) && (date.month <= MONTH_DEC)
                   && (date.day != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ok_reg    <= a_ok_next;
        a_p_reg     <= a_p_next;
        a_month_reg <= date.month;
        a_day_reg   <= date.day;
        a_cent_reg  <= a_cent_next;
    end

    // stage b: leap year, day check, ordinal day, days before the year
    logic                  b_valid_reg;
    logic                  b_ok_reg,  b_ok_next;
    logic [DOY_W-1:0]      b_doy_reg, b_doy_next;
    logic [ABS_W-1:0]      b_dby_reg, b_dby_next;
    logic [YEAR_W-1:0]     b_rem100;
    logic                  b_leap;

    always_comb
    begin
        b_rem100   = a_p_reg - YEAR_W'({a_cent_reg, 6'd0} + {a_cent_reg, 5'd0}
                                       + {a_cent_reg, 2'd0});
        // year = p + 1 is leap when p mod 4 is 3, unless it ends a century
        // that is not a multiple of 400
        b_leap     = (a_p_reg[1:0] == 2'd3)
                  && ((b_rem100 != 14'd99) || (a_cent_reg[1:0] == 2'd3));
        b_ok_next  = a_ok_reg && (a_day_reg <= month_days(a_month_reg, b_leap));
        b_doy_next = month_offset(a_month_reg) + {4'd0, a_day_reg}
                   + {8'd0, b_leap && (a_month_reg > MONTH_FEB)};
        if (!b_ok_next)
        begin
            b_doy_next = '0;
        end
        b_dby_next = {9'd0, a_p_reg} * DAYS_PER_YEAR
                   + {11'd0, a_p_reg[YEAR_W-1:2]}
                   - {15'd0, a_cent_reg}
                   + {17'd0, a_cent_reg[CENT_W-1:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ok_reg  <= b_ok_next;
        b_doy_reg <= b_doy_next;
        b_dby_reg <= b_dby_next;
    end

    // stage c: absolute day and distance from the epoch
    logic                  c_valid_reg;
    span_t                 c_span_reg, c_span_next;
    logic [ABS_W-1:0]      c_abs;
    logic [ABS_W-1:0]      c_diff;

    always_comb
    begin
        c_abs                   = b_dby_reg + {14'd0, b_doy_reg};
        c_diff                  = c_abs - EPOCH_ABS;
        c_span_next.day_of_year = b_doy_reg;
        c_span_next.elapsed     = '0;
        if (!b_ok_reg)
        begin
            c_span_next.status = STATUS_INVALID;
        end
        else if (c_abs < EPOCH_ABS)
        begin
            c_span_next.status = STATUS_EARLY;
        end
        else
        begin
            c_span_next.status  = STATUS_OK;
            c_span_next.elapsed = c_diff[ELAPSED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_span_reg <= c_span_next;
    end

    assign span_valid = c_valid_reg;
    assign span       = c_span_reg;

endmodule

`default_nettype wire
